// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the ARP responder RTL.
// Used by files that take this header with an include; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/arp_rr_pkg.sv -----
// Package for the ARP request responder: constants, reply job type, byte helpers.
// No dependencies.
`timescale 1ns / 1ps

package arp_rr_pkg;

   localparam logic [4:0]  ARP_LEN    = 5'd28;
   localparam logic [4:0]  LAST_IDX   = 5'd27;
   localparam logic [15:0] HW_TYPE    = 16'h0001;
   localparam logic [15:0] PROTO_TYPE = 16'h0800;
   localparam logic [7:0]  HW_LEN     = 8'd6;
   localparam logic [7:0]  PROTO_LEN  = 8'd4;
   localparam logic [15:0] OP_REQUEST = 16'h0001;
   localparam logic [15:0] OP_REPLY   = 16'h0002;

   localparam logic [63:0] REQ_HEADER = {HW_TYPE, PROTO_TYPE, HW_LEN, PROTO_LEN, OP_REQUEST};
   localparam logic [63:0] RSP_HEADER = {HW_TYPE, PROTO_TYPE, HW_LEN, PROTO_LEN, OP_REPLY};

   localparam logic [1:0] CSR_OWN_MAC  = 2'd0;
   localparam logic [1:0] CSR_OWN_IPV4 = 2'd1;

   typedef struct packed {
      logic [47:0] own_mac;
      logic [31:0] own_ipv4;
      logic [47:0] peer_mac;
      logic [31:0] peer_ipv4;
   } reply_job_type;

   // expected request header byte, wire order
   function automatic logic [7:0] req_header_byte(input logic [2:0] idx);
      return REQ_HEADER[{~idx, 3'b000} +: 8];
   endfunction

   // reply byte idx (0..27) of a job, wire order
   function automatic logic [7:0] reply_byte(input reply_job_type job,
                                             input logic [4:0] idx);
      logic [223:0] frame;
      logic [4:0]   sel;
      frame = {RSP_HEADER, job.own_mac, job.own_ipv4, job.peer_mac, job.peer_ipv4};
      sel   = LAST_IDX - idx;
      return frame[{sel, 3'b000} +: 8];
   endfunction

endpackage

// ----- rtl/core/arp_rr_front.sv -----
// Front end: parses incoming ARP payload bytes and issues a reply job per match.
// Depends on arp_rr_pkg.
`timescale 1ns / 1ps

module arp_rr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_rx_byte,
   input  logic                      req_frame_start,
   input  logic [10:0]               req_payload_length,
   input  logic [47:0]               own_mac,
   input  logic [31:0]               own_ipv4,
   input  logic                      queue_full,
   output logic                      push,
   output arp_rr_pkg::reply_job_type push_job
);

   logic [4:0]  pos_ff, pos_in, pos;
   logic        hdr_ok_ff, hdr_ok_in, hdr_ok;
   logic        tgt_ok_ff, tgt_ok_in, tgt_ok;
   logic [47:0] peer_mac_ff, peer_mac_in;
   logic [31:0] peer_ipv4_ff, peer_ipv4_in;
   logic        accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      pos    = req_frame_start ? 5'd0 : pos_ff;
      hdr_ok = req_frame_start ? (req_payload_length >= 11'(arp_rr_pkg::ARP_LEN)) : hdr_ok_ff;
      tgt_ok = req_frame_start ? 1'b1 : tgt_ok_ff;

      pos_in       = pos_ff;
      hdr_ok_in    = hdr_ok_ff;
      tgt_ok_in    = tgt_ok_ff;
      peer_mac_in  = peer_mac_ff;
      peer_ipv4_in = peer_ipv4_ff;

      if (accept) begin
         pos_in    = pos;
         hdr_ok_in = hdr_ok;
         tgt_ok_in = tgt_ok;
         if (pos < arp_rr_pkg::ARP_LEN) begin
            if (pos < 5'd8) begin
               if (req_rx_byte != arp_rr_pkg::req_header_byte(pos[2:0])) begin
                  hdr_ok_in = 1'b0;
               end
            end else if (pos < 5'd14) begin
               peer_mac_in = {peer_mac_ff[39:0], req_rx_byte};
            end else if (pos < 5'd18) begin
               peer_ipv4_in = {peer_ipv4_ff[23:0], req_rx_byte};
            end else if (pos >= 5'd24) begin
               if (req_rx_byte != own_ipv4[{~pos[1:0], 3'b000} +: 8]) begin
                  tgt_ok_in = 1'b0;
               end
            end
            pos_in = pos + 5'd1;
         end
      end

      push = accept && (pos == arp_rr_pkg::LAST_IDX) && hdr_ok_in && tgt_ok_in;

      push_job.own_mac   = own_mac;
      push_job.own_ipv4  = own_ipv4;
      push_job.peer_mac  = peer_mac_ff;
      push_job.peer_ipv4 = peer_ipv4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= arp_rr_pkg::ARP_LEN;
         hdr_ok_ff    <= 1'b0;
         tgt_ok_ff    <= 1'b0;
         peer_mac_ff  <= '0;
         peer_ipv4_ff <= '0;
      end else begin
         pos_ff       <= pos_in;
         hdr_ok_ff    <= hdr_ok_in;
         tgt_ok_ff    <= tgt_ok_in;
         peer_mac_ff  <= peer_mac_in;
         peer_ipv4_ff <= peer_ipv4_in;
      end
   end

endmodule

// ----- rtl/core/arp_rr_queue.sv -----
// Two-entry queue of reply jobs between the front end and the reply serializer.
// Depends on arp_rr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arp_rr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  arp_rr_pkg::reply_job_type push_job,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output arp_rr_pkg::reply_job_type head_job
);

   arp_rr_pkg::reply_job_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push, !full)
   `ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, pop, head_valid)
   `ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, count_ff != 2'd3)

endmodule

// ----- rtl/core/arp_rr_back.sv -----
// Back end: serializes the reply job at the queue head into 28 output bytes.
// Depends on arp_rr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arp_rr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_valid,
   input  arp_rr_pkg::reply_job_type job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_tx_byte,
   output logic                      rsp_tx_last
);

   logic [4:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       load;

   assign rsp_valid   = valid_ff;
   assign rsp_tx_byte = byte_ff;
   assign rsp_tx_last = last_ff;

   always_comb begin
      load     = job_valid && (!valid_ff || !rsp_stall);
      pop      = load && (idx_ff == arp_rr_pkg::LAST_IDX);
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         byte_in  = arp_rr_pkg::reply_byte(job, idx_ff);
         last_in  = (idx_ff == arp_rr_pkg::LAST_IDX);
         idx_in   = last_in ? 5'd0 : idx_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 5'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   `ASSERT_IMPLIES(a_last_wraps_index, clock, reset, valid_ff && last_ff, idx_ff == 5'd0)
   `ASSERT_IMPLIES(a_midreply_has_job, clock, reset, idx_ff != 5'd0, job_valid)
   `ASSERT_NEXT(a_index_steps, clock, reset, load && idx_ff != arp_rr_pkg::LAST_IDX,
      idx_ff == $past(idx_ff) + 5'd1)

endmodule

// ----- rtl/core/arp_request_responder_core.sv -----
// Top level of the ARP request responder: station registers, front end, queue, back end.
// Depends on arp_rr_pkg, arp_rr_front, arp_rr_queue, arp_rr_back.
//
// channel  dir  handshake          payload
// req_     in   valid / stall      rx_byte[8], frame_start, payload_length[11]
// rsp_     out  valid / stall      tx_byte[8], tx_last
// csr_     in   valid / ready      index[2], wdata[48]
//
// Unstalled, one request byte per cycle; a reply streams out as 28 bytes, one per cycle.
// Replies wait in a two-entry job queue; input stalls only while it is full.
// After the 28th request byte the job is queued, then byte 0 is registered in the back end.
// Synchronous reset; station registers clear to zero, csr_ready is always high.
`timescale 1ns / 1ps

module arp_request_responder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   input  logic [10:0] req_payload_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   logic [47:0] own_mac_ff, own_mac_in;
   logic [31:0] own_ipv4_ff, own_ipv4_in;
   logic        push, pop, full, head_valid;
   arp_rr_pkg::reply_job_type push_job, head_job;

   assign csr_ready = 1'b1;

   always_comb begin
      own_mac_in  = own_mac_ff;
      own_ipv4_in = own_ipv4_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            arp_rr_pkg::CSR_OWN_MAC:  own_mac_in  = csr_wdata;
            arp_rr_pkg::CSR_OWN_IPV4: own_ipv4_in = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff  <= '0;
         own_ipv4_ff <= '0;
      end else begin
         own_mac_ff  <= own_mac_in;
         own_ipv4_ff <= own_ipv4_in;
      end
   end

   arp_rr_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .req_frame_start    (req_frame_start),
      .req_payload_length (req_payload_length),
      .own_mac            (own_mac_ff),
      .own_ipv4           (own_ipv4_ff),
      .queue_full         (full),
      .push               (push),
      .push_job           (push_job)
   );

   arp_rr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   arp_rr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (head_valid),
      .job         (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_tx_last (rsp_tx_last)
   );

endmodule
